// ===== src/klex_pkg.sv =====
`default_nettype none

package klex_pkg;

   localparam int OFFSET_WIDTH_DEF = 16;
   localparam int TOKEN_FIELD_W    = 16;
   localparam int FIFO_DEPTH       = 4;
   localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_PERIOD = 8'h2E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LOW_G  = 8'h67;
   localparam logic [7:0] CH_LOW_C  = 8'h63;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam logic KW_GET      = 1'b0;
   localparam logic KW_CONTAINS = 1'b1;

   typedef enum logic [3:0] {
      KIND_ASSIGN   = 4'd0,
      KIND_GET      = 4'd1,
      KIND_CONTAINS = 4'd2,
      KIND_PERIOD   = 4'd3,
      KIND_COMMA    = 4'd4,
      KIND_NEWLINE  = 4'd5,
      KIND_STRING   = 4'd6,
      KIND_IDENT    = 4'd7,
      KIND_EOF      = 4'd8,
      KIND_INVALID  = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_IDENT   = 2'd1,
      MODE_KEYWORD = 2'd2,
      MODE_STRING  = 2'd3
   } mode_type;

   typedef struct packed {
      logic                     last;
      logic [TOKEN_FIELD_W-1:0] length;
      logic [TOKEN_FIELD_W-1:0] start;
      kind_type                 kind;
   } tok_type;

   typedef struct packed {
      logic                  room;
      logic                  empty;
      logic [FIFO_CNT_W-1:0] count;
   } fifo_stat_type;

   function automatic logic is_word(input logic [7:0] b);
      return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) || (b == CH_UNDER);
   endfunction

   function automatic logic [3:0] kw_len(input logic cand);
      return (cand == KW_CONTAINS) ? 4'd8 : 4'd3;
   endfunction

   // letter expected at position p of the candidate keyword
   function automatic logic [7:0] kw_char(input logic cand, input logic [2:0] p);
      logic [7:0] ch;
      ch = 8'h00;
      if (cand == KW_GET) begin
         case (p)
            3'd0:    ch = "g";
            3'd1:    ch = "e";
            3'd2:    ch = "t";
            default: ch = 8'h00;
         endcase
      end else begin
         case (p)
            3'd0:    ch = "c";
            3'd1:    ch = "o";
            3'd2:    ch = "n";
            3'd3:    ch = "t";
            3'd4:    ch = "a";
            3'd5:    ch = "i";
            3'd6:    ch = "n";
            3'd7:    ch = "s";
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== src/klex_core.sv =====
`default_nettype none

module klex_core import klex_pkg::*; #(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] text_byte,
   output tok_type         tok0,
   output tok_type         tok1,
   output logic [1:0]      tok_count
);

   mode_type                mode_ff, mode_in;
   logic [2:0]              prog_ff, prog_in;
   logic                    cand_ff, cand_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [OFFSET_WIDTH-1:0] start_ff, start_in;

   logic [OFFSET_WIDTH-1:0] span;
   logic                    word;

   // byte handled at a token boundary
   logic                    idle_emit;
   kind_type                idle_kind;
   logic [TOKEN_FIELD_W-1:0] idle_len;
   mode_type                idle_mode;
   logic [OFFSET_WIDTH-1:0] idle_start;
   logic [2:0]              idle_prog;
   logic                    idle_cand;

   // token being collected, emitted when it closes
   logic                    first_v;
   kind_type                first_kind;
   logic [TOKEN_FIELD_W-1:0] first_len;
   logic                    use_idle;
   logic [3:0]              prog_next;
   logic                    second_v;
   tok_type                 first_tok, idle_tok;

   assign span = offset_ff - start_ff;
   assign word = is_word(text_byte);

   always_comb begin
      idle_emit  = 1'b0;
      idle_kind  = KIND_INVALID;
      idle_len   = TOKEN_FIELD_W'(1);
      idle_mode  = MODE_IDLE;
      idle_start = start_ff;
      idle_prog  = '0;
      idle_cand  = KW_GET;
      case (text_byte)
         CH_NUL: begin
            idle_emit = 1'b1;
            idle_kind = KIND_EOF;
            idle_len  = '0;
         end
         CH_SPACE: begin
            idle_emit = 1'b0;
         end
         CH_EQ: begin
            idle_emit = 1'b1;
            idle_kind = KIND_ASSIGN;
         end
         CH_PERIOD: begin
            idle_emit = 1'b1;
            idle_kind = KIND_PERIOD;
         end
         CH_COMMA: begin
            idle_emit = 1'b1;
            idle_kind = KIND_COMMA;
         end
         CH_LF, CH_CR: begin
            idle_emit = 1'b1;
            idle_kind = KIND_NEWLINE;
         end
         CH_QUOTE: begin
            idle_mode  = MODE_STRING;
            idle_start = offset_ff + 1'b1;
         end
         default: begin
            idle_start = offset_ff;
            if (text_byte == CH_LOW_G || text_byte == CH_LOW_C) begin
               idle_mode = MODE_KEYWORD;
               idle_cand = (text_byte == CH_LOW_C) ? KW_CONTAINS : KW_GET;
               idle_prog = 3'd1;
            end else if (word) begin
               idle_mode = MODE_IDENT;
            end else begin
               idle_emit = 1'b1;
               idle_kind = KIND_INVALID;
            end
         end
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      prog_in    = prog_ff;
      cand_in    = cand_ff;
      start_in   = start_ff;
      offset_in  = (text_byte == CH_NUL) ? '0 : offset_ff + 1'b1;
      first_v    = 1'b0;
      first_kind = KIND_IDENT;
      first_len  = TOKEN_FIELD_W'(span);
      use_idle   = 1'b0;
      prog_next  = {1'b0, prog_ff} + 4'd1;
      case (mode_ff)
         MODE_STRING: begin
            if (text_byte == CH_QUOTE) begin
               first_v    = 1'b1;
               first_kind = KIND_STRING;
               mode_in    = MODE_IDLE;
            end else if (text_byte == CH_NUL) begin
               first_v    = 1'b1;
               first_kind = KIND_INVALID;
               use_idle   = 1'b1;
            end
         end
         MODE_KEYWORD: begin
            if ({1'b0, prog_ff} < kw_len(cand_ff) && text_byte == kw_char(cand_ff, prog_ff)) begin
               if (prog_next >= kw_len(cand_ff)) begin
                  first_v    = 1'b1;
                  first_kind = (cand_ff == KW_CONTAINS) ? KIND_CONTAINS : KIND_GET;
                  first_len  = TOKEN_FIELD_W'(kw_len(cand_ff));
                  mode_in    = MODE_IDLE;
                  prog_in    = '0;
                  cand_in    = KW_GET;
               end else begin
                  prog_in = prog_next[2:0];
               end
            end else if (word) begin
               mode_in = MODE_IDENT;
               prog_in = '0;
               cand_in = KW_GET;
            end else begin
               first_v  = 1'b1;
               use_idle = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (!word) begin
               first_v  = 1'b1;
               use_idle = 1'b1;
            end
         end
         default: begin
            use_idle = 1'b1;
         end
      endcase
      if (use_idle) begin
         mode_in  = idle_mode;
         start_in = idle_start;
         prog_in  = idle_prog;
         cand_in  = idle_cand;
      end
   end

   assign second_v = use_idle && idle_emit;

   always_comb begin
      first_tok.kind   = first_kind;
      first_tok.start  = TOKEN_FIELD_W'(start_ff);
      first_tok.length = first_len;
      first_tok.last   = !second_v;
      idle_tok.kind    = idle_kind;
      idle_tok.start   = TOKEN_FIELD_W'(offset_ff);
      idle_tok.length  = idle_len;
      idle_tok.last    = 1'b1;
      if (first_v) begin
         tok0      = first_tok;
         tok1      = idle_tok;
         tok_count = second_v ? 2'd2 : 2'd1;
      end else begin
         tok0      = idle_tok;
         tok1      = idle_tok;
         tok_count = second_v ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         prog_ff   <= '0;
         cand_ff   <= KW_GET;
         offset_ff <= '0;
         start_ff  <= '0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         prog_ff   <= prog_in;
         cand_ff   <= cand_in;
         offset_ff <= offset_in;
         start_ff  <= start_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/klex_fifo.sv =====
`default_nettype none

module klex_fifo import klex_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] push_count,
   input  wire tok_type    push0,
   input  wire tok_type    push1,
   input  wire logic       pop,
   output tok_type         head,
   output fifo_stat_type   stat
);

   tok_type               mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_PTR_W-1:0] wr_next;

   assign wr_next   = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);

   assign head       = mem[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.empty = (count_ff == '0);
   // room for the two beats a single byte can cause
   assign stat.room  = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem[wr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/keyword_string_identifier_lexer.sv =====
`default_nettype none

// Channel   Dir  Beat                Fields (tdata / tuser / tlast)
// req_      in   one text byte       tdata[7:0] text_byte
// rsp_      out  one token           tdata[3:0] kind, [19:4] start, [35:20] length;
//                                    tlast = last token caused by the byte
//
// One byte per cycle is taken while the queue has room: a byte sits in the input register,
// where the lexer state and a compare on the byte decide its tokens, and then lands in a
// four-entry token queue that feeds rsp_. A byte can cause two tokens; the input
// register holds while the queue has room for fewer than two.
// Reset (synchronous, active high) returns the lexer between tokens at offset zero
// and empties the queue.

module keyword_string_identifier_lexer import klex_pkg::*; #(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [3:0] token_kind, [19:4] token_start,
                                         // [35:20] token_length, [39:36] zero
   output logic             rsp_tlast    // last_of_run
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          advance;
   logic          pop;
   tok_type       tok0, tok1, head;
   logic [1:0]    tok_count;
   logic [1:0]    push_count;
   fifo_stat_type stat;

   assign advance     = in_valid_ff && stat.room;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign push_count  = advance ? tok_count : 2'd0;
   assign pop         = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   klex_core #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .text_byte (in_byte_ff),
      .tok0      (tok0),
      .tok1      (tok1),
      .tok_count (tok_count)
   );

   klex_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (tok0),
      .push1      (tok1),
      .pop        (pop),
      .head       (head),
      .stat       (stat)
   );

   assign rsp_tvalid = !stat.empty;
   assign rsp_tdata  = {4'b0000, head.length, head.start, head.kind};
   assign rsp_tlast  = head.last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("token queue overfilled");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |=> rsp_tvalid)
      else $error("pushed token not presented");

   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled input byte lost");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (push_count == 2'd2) |-> stat.room)
      else $error("double push without room");

endmodule

`default_nettype wire
